[rtl/ple_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg: shared types and codes for the positional list engine
// Word layouts of both channels, operation and status codes, and the default
// list depth.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 5;
  localparam int LEN_W        = 5;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_FIND   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]               status;
    logic                     found;
    logic [LEN_W-1:0]         length;
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] back;
    logic                     empty_res;
  } out_word_t;

  // Per-cell load selects, one hot or all zero.
  typedef struct packed {
    logic load_value;
    logic load_left;
    logic load_right;
  } cell_ctl_t;

endpackage : ple_pkg
`default_nettype wire

[rtl/ple_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ple_cell: one list slot
// Holds one entry; loads the new value, its left neighbor (insert shift) or
// its right neighbor (remove shift), and reports a search hit and its value
// when it is the back entry.
// ----------------------------------------------------------------------------
module ple_cell (
  input  wire logic                             clk,
  input  wire ple_pkg::cell_ctl_t               ctl,
  input  wire logic signed [ple_pkg::DATA_W-1:0] new_value,
  input  wire logic signed [ple_pkg::DATA_W-1:0] left_data,
  input  wire logic signed [ple_pkg::DATA_W-1:0] right_data,
  input  wire logic signed [ple_pkg::DATA_W-1:0] key,
  input  wire logic                             is_live,
  input  wire logic                             is_last,
  output logic signed [ple_pkg::DATA_W-1:0]      data,
  output logic                                  match,
  output logic signed [ple_pkg::DATA_W-1:0]      back_part
);

  logic signed [ple_pkg::DATA_W-1:0] data_r;
  logic signed [ple_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.load_value) begin
      data_nxt = new_value;
    end else if (ctl.load_left) begin
      data_nxt = left_data;
    end else if (ctl.load_right) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data      = data_r;
  assign match     = is_live && (data_r == key);
  assign back_part = is_last ? data_r : '0;

endmodule : ple_cell
`default_nettype wire

[rtl/positional_list_engine_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine_top: bounded ordered list with insert/remove/find
// The row of cells shifts on acceptance; search hit, back value and status are
// gathered as the result word is loaded into the output register. A new word is
// not accepted until that result has entered the output register.
// in_ready stays low while a result cannot enter a stalled output register.
// Reset (rst_n low, synchronous) empties the list; cell contents are not reset.
// ----------------------------------------------------------------------------
module positional_list_engine_top #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ple_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ple_pkg::out_word_t      out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

  logic [CW-1:0]                       count_r, count_nxt;
  logic                                busy_r;
  logic [1:0]                          mode_r;
  logic [1:0]                          status_r;
  logic signed [ple_pkg::DATA_W-1:0]   key_r;
  logic                                out_valid_r;
  ple_pkg::out_word_t                  out_data_r;

  logic        accept;
  logic [1:0]  status_nxt;
  logic        do_ins, do_rem;
  logic [PW-1:0] pos_w, cnt_w;

  logic signed [ple_pkg::DATA_W-1:0] cell_data [CAPACITY];
  logic signed [ple_pkg::DATA_W-1:0] cell_back [CAPACITY];
  logic [CAPACITY-1:0]               cell_match;

  logic                              any_match;
  logic signed [ple_pkg::DATA_W-1:0] back_val;
  logic                              load_out;

  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;
  assign pos_w    = PW'(in_data.position);
  assign cnt_w    = PW'(count_r);

  always_comb begin
    status_nxt = ple_pkg::ST_OK;
    case (in_data.mode)
      ple_pkg::MODE_INSERT: begin
        if (count_r >= CW'(CAPACITY)) begin
          status_nxt = ple_pkg::ST_FULL;
        end else if (pos_w > cnt_w) begin
          status_nxt = ple_pkg::ST_RANGE;
        end
      end
      ple_pkg::MODE_REMOVE: begin
        if (count_r == '0) begin
          status_nxt = ple_pkg::ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status_nxt = ple_pkg::ST_RANGE;
        end
      end
      default: status_nxt = ple_pkg::ST_OK;
    endcase
  end

  assign do_ins = accept && (in_data.mode == ple_pkg::MODE_INSERT) &&
                  (status_nxt == ple_pkg::ST_OK);
  assign do_rem = accept && (in_data.mode == ple_pkg::MODE_REMOVE) &&
                  (status_nxt == ple_pkg::ST_OK);

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rem) begin
      count_nxt = count_r - 1'b1;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      ple_pkg::cell_ctl_t                ctl;
      logic signed [ple_pkg::DATA_W-1:0] left_d, right_d;

      assign ctl.load_value = do_ins && (pos_w == PW'(gi));
      assign ctl.load_left  = do_ins && (PW'(gi) > pos_w);
      assign ctl.load_right = do_rem && (PW'(gi) >= pos_w);

      if (gi == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_mid_l
        assign left_d = cell_data[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_end
        assign right_d = '0;
      end else begin : g_mid_r
        assign right_d = cell_data[gi+1];
      end

      ple_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .new_value  (in_data.value),
        .left_data  (left_d),
        .right_data (right_d),
        .key        (key_r),
        .is_live    (CW'(gi) < count_r),
        .is_last    (CW'(gi + 1) == count_r),
        .data       (cell_data[gi]),
        .match      (cell_match[gi]),
        .back_part  (cell_back[gi])
      );
    end
  endgenerate

  assign any_match = |cell_match;

  always_comb begin
    back_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_val = back_val | cell_back[i];
    end
  end

  assign load_out = busy_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (load_out) begin
        busy_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= in_data.mode;
      status_r <= status_nxt;
      key_r    <= in_data.value;
    end
    if (load_out) begin
      out_data_r.status    <= status_r;
      out_data_r.found     <= (mode_r == ple_pkg::MODE_FIND) && any_match;
      out_data_r.length    <= ple_pkg::LEN_W'(count_r);
      out_data_r.front     <= (count_r != '0) ? cell_data[0] : '0;
      out_data_r.back      <= back_val;
      out_data_r.empty_res <= (count_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : positional_list_engine_top
`default_nettype wire

[rtl/ple_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ple_checker: port-level checks for the positional list engine
// Watches both channels of the top level; attached by bind below.
// ----------------------------------------------------------------------------
module ple_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire ple_pkg::in_word_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire ple_pkg::out_word_t out_data
);

  // one word in flight between the cell row and the output register
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.empty_res |-> out_data.length == '0)
    else $error("empty flag with nonzero length");

  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.empty_res |-> out_data.front == '0 && out_data.back == '0)
    else $error("empty list reports front or back value");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.status == ple_pkg::ST_OK &&
    !out_data.empty_res)
    else $error("hit reported with error status or empty list");

endmodule : ple_checker

bind positional_list_engine_top ple_checker u_ple_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the positional list engine
// Drives insert, remove, find and unused-mode words with bursty input timing
// and receiver stalls, including one long output hold that backs up the input.
// An in-bench list mirror predicts each result word, and a checker compares
// every field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CAP            = ple_pkg::CAPACITY_DEF;
  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  localparam int         RX_HOLD_CYCLES = 80;

  typedef logic [ple_pkg::POS_W-1:0] pos_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  ple_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_ready;
  ple_pkg::out_word_t out_data;

  // list mirror
  logic signed [ple_pkg::DATA_W-1:0] list_mem [CAP];
  int                                list_len;

  ple_pkg::out_word_t list_reports_q[$];
  ple_pkg::out_word_t report_want;
  int                 n_mismatches;

  int tx_burst_left;
  bit tx_gaps_on;
  bit rx_stalls_on;
  bit rx_hold_req;

  positional_list_engine_top #(.CAPACITY(CAP)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic ple_pkg::in_word_t mk_word(input logic [1:0] mode,
                                                input logic [ple_pkg::DATA_W-1:0] value,
                                                input pos_t position);
    ple_pkg::in_word_t w;
    w.mode     = mode;
    w.value    = value;
    w.position = position;
    return w;
  endfunction

  // Applies one word to the mirror and returns the report the block should give.
  function automatic ple_pkg::out_word_t list_apply(input ple_pkg::in_word_t w);
    ple_pkg::out_word_t r;
    int                 pos;
    int                 i;
    r      = '0;
    pos    = int'(w.position);
    r.status = ple_pkg::ST_OK;
    case (w.mode)
      ple_pkg::MODE_INSERT: begin
        // full is checked ahead of position
        if (list_len >= CAP) begin
          r.status = ple_pkg::ST_FULL;
        end else if (pos > list_len) begin
          r.status = ple_pkg::ST_RANGE;
        end else begin
          for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = w.value;
          list_len++;
        end
      end
      ple_pkg::MODE_REMOVE: begin
        if (list_len == 0) begin
          r.status = ple_pkg::ST_EMPTY;
        end else if (pos >= list_len) begin
          r.status = ple_pkg::ST_RANGE;
        end else begin
          for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      ple_pkg::MODE_FIND: begin
        for (i = 0; i < list_len; i++) begin
          if (list_mem[i] == w.value) r.found = 1'b1;
        end
      end
      default: ;
    endcase
    r.length    = list_len[ple_pkg::LEN_W-1:0];
    r.empty_res = (list_len == 0);
    if (list_len > 0) begin
      r.front = list_mem[0];
      r.back  = list_mem[list_len-1];
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input ple_pkg::in_word_t w);
    int gap;
    if (tx_gaps_on && tx_burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      tx_burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    list_reports_q.push_back(list_apply(w));
    if (tx_burst_left > 0) tx_burst_left--;
    @(negedge clk);
  endtask

  task automatic flag_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (list_reports_q.size() == 0) begin
        $error("result word with nothing pending");
        n_mismatches++;
      end else begin
        report_want = list_reports_q.pop_front();
        flag_field("status", report_want.status, out_data.status);
        flag_field("found", report_want.found, out_data.found);
        flag_field("length", report_want.length, out_data.length);
        flag_field("front", report_want.front, out_data.front);
        flag_field("back", report_want.back, out_data.back);
        flag_field("empty_res", report_want.empty_res, out_data.empty_res);
      end
    end
  end

  // Receiver: alternating ready/stall runs, or a long hold on request.
  initial begin
    bit rx_on;
    int rx_run;
    rx_on  = 1'b1;
    rx_run = 0;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end else if (!rx_stalls_on) begin
        out_ready <= 1'b1;
      end else begin
        if (rx_run == 0) begin
          rx_on  = ~rx_on;
          rx_run = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 6);
        end
        rx_run--;
        out_ready <= rx_on;
      end
    end
  end

  task automatic test_empty_list_errors();
    send_word(mk_word(ple_pkg::MODE_REMOVE, 32'd0, 5'd0));
    send_word(mk_word(ple_pkg::MODE_REMOVE, 32'd0, 5'd31));
    send_word(mk_word(ple_pkg::MODE_INSERT, 32'd3, 5'd1));
    send_word(mk_word(ple_pkg::MODE_FIND, 32'd0, 5'd0));
  endtask

  task automatic test_insert_positions();
    send_word(mk_word(ple_pkg::MODE_INSERT, 32'h7FFF_FFFF, 5'd0));
    send_word(mk_word(ple_pkg::MODE_INSERT, 32'h8000_0000, 5'd1));  // append at length
    send_word(mk_word(ple_pkg::MODE_INSERT, 32'd0, 5'd0));
    send_word(mk_word(ple_pkg::MODE_INSERT, 32'hFFFF_FFFF, 5'd2));
    send_word(mk_word(ple_pkg::MODE_INSERT, 32'd5, 5'd5));
    send_word(mk_word(ple_pkg::MODE_INSERT, 32'd7, 5'd31));
  endtask

  // list is now 0, max, -1, min
  task automatic test_find();
    send_word(mk_word(ple_pkg::MODE_FIND, 32'hFFFF_FFFF, 5'd0));
    send_word(mk_word(ple_pkg::MODE_FIND, 32'h8000_0000, 5'd31));
    send_word(mk_word(ple_pkg::MODE_FIND, 32'd1, 5'd0));
    send_word(mk_word(ple_pkg::MODE_FIND, 32'd0, 5'd16));
  endtask

  task automatic test_remove_positions();
    send_word(mk_word(ple_pkg::MODE_REMOVE, 32'd0, 5'd4));
    send_word(mk_word(ple_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 5'd31));
    send_word(mk_word(ple_pkg::MODE_REMOVE, 32'd0, 5'd3));          // back entry
    send_word(mk_word(ple_pkg::MODE_REMOVE, 32'd0, 5'd0));
    send_word(mk_word(ple_pkg::MODE_REMOVE, 32'd0, 5'd1));
    send_word(mk_word(ple_pkg::MODE_REMOVE, 32'd0, 5'd0));          // only entry
    send_word(mk_word(ple_pkg::MODE_REMOVE, 32'd0, 5'd0));
  endtask

  task automatic test_unused_mode();
    send_word(mk_word(MODE_UNUSED, 32'hFFFF_FFFF, 5'd31));
    send_word(mk_word(ple_pkg::MODE_INSERT, 32'd9, 5'd0));
    send_word(mk_word(MODE_UNUSED, 32'd9, 5'd0));
  endtask

  // Mostly well-formed positions against the current length, some noise.
  task automatic run_random(input int n, input int pct_ins, input int pct_rem,
                            input int pct_find);
    int                         roll;
    logic [1:0]                 mode;
    logic [ple_pkg::DATA_W-1:0] v;
    pos_t                       pos;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < pct_ins) mode = ple_pkg::MODE_INSERT;
      else if (roll < pct_ins + pct_rem) mode = ple_pkg::MODE_REMOVE;
      else if (roll < pct_ins + pct_rem + pct_find) mode = ple_pkg::MODE_FIND;
      else mode = MODE_UNUSED;
      case ($urandom_range(0, 7))
        0, 1:    v = $urandom_range(0, 7) - 4;   // small pool, gives duplicates
        2:       v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        default: v = $urandom;
      endcase
      pos = pos_t'($urandom_range(0, 31));
      if ($urandom_range(0, 9) != 0) begin
        if (mode == ple_pkg::MODE_INSERT) begin
          pos = pos_t'($urandom_range(0, list_len));
        end else if (mode == ple_pkg::MODE_REMOVE && list_len > 0) begin
          pos = pos_t'($urandom_range(0, list_len - 1));
        end
      end
      if (mode == ple_pkg::MODE_FIND && list_len > 0 && $urandom_range(0, 1) == 1) begin
        v = list_mem[$urandom_range(0, list_len - 1)];
      end
      send_word(mk_word(mode, v, pos));
    end
  endtask

  task automatic test_random_fill();
    run_random(150, 70, 15, 10);
  endtask

  task automatic test_random_drain();
    run_random(150, 20, 70, 5);
  endtask

  task automatic test_random_mix();
    run_random(250, 45, 35, 15);
  endtask

  task automatic test_output_backpressure();
    rx_hold_req = 1'b1;
    tx_gaps_on  = 1'b0;
    run_random(40, 45, 30, 20);
    tx_gaps_on  = 1'b1;
  endtask

  task automatic test_back_to_back();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    run_random(150, 40, 35, 20);
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  initial begin
    in_valid      <= 1'b0;
    in_data       <= '0;
    rst_n         <= 1'b0;
    list_len      = 0;
    n_mismatches  = 0;
    tx_burst_left = 0;
    tx_gaps_on    = 1'b1;
    rx_stalls_on  = 1'b1;
    rx_hold_req   = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_list_errors();
    test_insert_positions();
    test_find();
    test_remove_positions();
    test_unused_mode();
    test_random_fill();
    test_random_drain();
    test_random_mix();
    test_output_backpressure();
    test_back_to_back();

    in_valid <= 1'b0;
    while (list_reports_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (n_mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule : tb_top

[sim.f]
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/positional_list_engine_top.sv
rtl/ple_checker.sv
bench/tb_top.sv
